// ===== rtl/uvsv_pkg.sv =====
// Shared constants, register codes and sine coefficients for the UV-sphere vertex generator.
package uvsv_pkg;

   // Index and angle resolution.
   localparam int COUNT_BITS = 8;
   localparam int ANGLE_BITS = 16;

   // Divider geometry: dividend, quotient and the top slice loaded as first remainder.
   localparam int DIV_W = COUNT_BITS + ANGLE_BITS;
   localparam int QUO_W = ANGLE_BITS + 1;
   localparam int TOP_W = DIV_W - QUO_W;

   // Pipeline depths of the sub-units and of the whole block.
   localparam int DIV_STAGES = QUO_W;
   localparam int SIN_STAGES = 7;
   localparam int LATENCY    = 1 + DIV_STAGES + SIN_STAGES + 2;

   // Clamp limits and defaults.
   localparam int SECTOR_COUNT_FLOOR = 3;
   localparam int STACK_COUNT_FLOOR  = 2;
   localparam logic [15:0] RADIUS_ONE = 16'd256;

   // Number formats.
   localparam int MAG_W = 31;
   localparam int X_W   = 17;
   localparam int POS_W = 17;
   localparam int NRM_W = 16;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      REG_RADIUS = 2'd0,
      REG_SECTOR = 2'd1,
      REG_STACK  = 2'd2
   } csr_index_type;

   // Taylor coefficients of sin(pi/2*x) in Q30.
   localparam logic [MAG_W-1:0] SC1 = 31'd1686629713;
   localparam logic [MAG_W-1:0] SC3 = 31'd693598668;
   localparam logic [MAG_W-1:0] SC5 = 31'd85569306;
   localparam logic [MAG_W-1:0] SC7 = 31'd5026995;
   localparam logic [MAG_W-1:0] SC9 = 31'd172272;
   localparam logic [MAG_W-1:0] Q30_ONE = 31'h4000_0000;

endpackage

// ===== rtl/uvsv_if.sv =====
// Channel interfaces for the grid point request and the vertex response.
interface uvsv_req_if;
   logic valid;
   logic ready;
   logic [uvsv_pkg::COUNT_BITS-1:0] stack_index;
   logic [uvsv_pkg::COUNT_BITS-1:0] sector_index;

   modport source (output valid, output stack_index, output sector_index, input ready);
   modport sink   (input valid, input stack_index, input sector_index, output ready);
endinterface

interface uvsv_rsp_if;
   logic valid;
   logic ready;
   logic signed [16:0] pos_x;
   logic signed [16:0] pos_y;
   logic signed [16:0] pos_z;
   logic signed [15:0] norm_x;
   logic signed [15:0] norm_y;
   logic signed [15:0] norm_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output norm_x, output norm_y, output norm_z, input ready);
   modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                   input norm_x, input norm_y, input norm_z, output ready);
endinterface

// ===== rtl/uvsv_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
module uvsv_divider (
   input  logic                                clock,
   input  logic                                en,
   input  logic [uvsv_pkg::DIV_W-1:0]          dividend,
   input  logic [uvsv_pkg::COUNT_BITS-1:0]     divisor,
   output logic [uvsv_pkg::QUO_W-1:0]          quotient
);

   localparam int CB = uvsv_pkg::COUNT_BITS;
   localparam int QW = uvsv_pkg::QUO_W;
   localparam int NS = uvsv_pkg::DIV_STAGES;

   logic [CB-1:0] rem_ff [NS];
   logic [QW-1:0] quo_ff [NS];
   logic [QW-1:0] num_ff [NS];
   logic [CB-1:0] div_ff [NS];

   genvar k;
   generate
      for (k = 0; k < NS; k++) begin : g_stage
         logic [CB-1:0] rem_prev;
         logic [QW-1:0] quo_prev;
         logic [QW-1:0] num_prev;
         logic [CB-1:0] div_prev;
         logic [CB:0]   trial;
         logic          fits;

         // The first stage loads the top slice of the dividend as remainder.
         if (k == 0) begin : g_first
            assign rem_prev = CB'(dividend[uvsv_pkg::DIV_W-1:QW]);
            assign quo_prev = '0;
            assign num_prev = dividend[QW-1:0];
            assign div_prev = divisor;
         end else begin : g_next
            assign rem_prev = rem_ff[k-1];
            assign quo_prev = quo_ff[k-1];
            assign num_prev = num_ff[k-1];
            assign div_prev = div_ff[k-1];
         end

         // Shift in the next dividend bit and subtract where the divisor fits.
         assign trial = {rem_prev, num_prev[QW-1]};
         assign fits  = (trial >= {1'b0, div_prev});

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k] <= fits ? CB'(trial - {1'b0, div_prev}) : CB'(trial);
               quo_ff[k] <= {quo_prev[QW-2:0], fits};
               num_ff[k] <= {num_prev[QW-2:0], 1'b0};
               div_ff[k] <= div_prev;
            end
         end
      end
   endgenerate

   assign quotient = quo_ff[NS-1];

endmodule

// ===== rtl/uvsv_sine.sv =====
// Pipelined sine of a phase: Horner polynomial in Q30, magnitude and sign.
module uvsv_sine (
   input  logic                               clock,
   input  logic                               en,
   input  logic [uvsv_pkg::ANGLE_BITS-1:0]    phase,
   output logic [uvsv_pkg::MAG_W-1:0]         mag,
   output logic                               neg
);

   localparam int AB = uvsv_pkg::ANGLE_BITS;
   localparam int MW = uvsv_pkg::MAG_W;
   localparam int XW = uvsv_pkg::X_W;

   logic [31:0]   wide;
   logic [1:0]    quad;
   logic [15:0]   frac;
   logic [XW-1:0] x_in;

   logic [XW-1:0] x0_ff, x1_ff, x2_ff, x3_ff, x4_ff, x5_ff;
   logic [1:0]    q0_ff, q1_ff, q2_ff, q3_ff, q4_ff, q5_ff;
   logic [XW-1:0] sq1_ff, sq2_ff, sq3_ff, sq4_ff;
   logic [MW-1:0] p2_ff, p3_ff, p4_ff, p5_ff;
   logic [MW-1:0] mag_ff;
   logic          neg_ff;

   logic [2*XW-1:0] sq_prod;
   logic [47:0]     h2_prod, h3_prod, h4_prod, h5_prod, fin_prod;
   logic [31:0]     fin_val;
   logic [MW-1:0]   mag_in;

   // Quadrant and mirrored fraction of the quarter turn.
   assign wide = {phase, {(32 - AB){1'b0}}};
   assign quad = wide[31:30];
   assign frac = wide[29:14];
   assign x_in = quad[0] ? (XW'(65536) - XW'(frac)) : XW'(frac);

   // Square of x in Q16.
   assign sq_prod = x0_ff * x0_ff;

   // Horner steps, one multiply and subtract per stage.
   assign h2_prod = 48'(uvsv_pkg::SC9) * 48'(sq1_ff);
   assign h3_prod = 48'(p2_ff) * 48'(sq2_ff);
   assign h4_prod = 48'(p3_ff) * 48'(sq3_ff);
   assign h5_prod = 48'(p4_ff) * 48'(sq4_ff);

   // Final multiply by x, then clamp to one.
   assign fin_prod = 48'(p5_ff) * 48'(x5_ff);
   assign fin_val  = fin_prod[47:16];
   assign mag_in   = (fin_val > 32'(uvsv_pkg::Q30_ONE)) ? uvsv_pkg::Q30_ONE : MW'(fin_val);

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff  <= x_in;
         q0_ff  <= quad;
         x1_ff  <= x0_ff;
         q1_ff  <= q0_ff;
         sq1_ff <= sq_prod[XW+15:16];
         x2_ff  <= x1_ff;
         q2_ff  <= q1_ff;
         sq2_ff <= sq1_ff;
         p2_ff  <= MW'(32'(uvsv_pkg::SC7) - h2_prod[47:16]);
         x3_ff  <= x2_ff;
         q3_ff  <= q2_ff;
         sq3_ff <= sq2_ff;
         p3_ff  <= MW'(32'(uvsv_pkg::SC5) - h3_prod[47:16]);
         x4_ff  <= x3_ff;
         q4_ff  <= q3_ff;
         sq4_ff <= sq3_ff;
         p4_ff  <= MW'(32'(uvsv_pkg::SC3) - h4_prod[47:16]);
         x5_ff  <= x4_ff;
         q5_ff  <= q4_ff;
         p5_ff  <= MW'(32'(uvsv_pkg::SC1) - h5_prod[47:16]);
         mag_ff <= mag_in;
         neg_ff <= q5_ff[1] && (mag_in != '0);
      end
   end

   assign mag = mag_ff;
   assign neg = neg_ff;

endmodule

// ===== rtl/uv_sphere_vertex_generator.sv =====
// Top level of the UV-sphere vertex generator.
//
// The request channel carries one grid point word (stack_index, sector_index);
// the response channel returns one vertex word: Q8.8 position and Q1.14 normal.
// Radius, sector count and stack count are written through the csr_ port and
// must only change while no word is in flight.
// A word enters in every cycle while the response side takes words, so the
// throughput is one vertex per cycle. A word passes in order through the
// clamping register, the pipelined angle dividers (one quotient bit per
// stage), the sine pipelines and the product registers.
// The whole pipeline advances together; when the receiver holds ready low with
// a word waiting, every stage holds and req_ch.ready falls, so nothing is lost
// or repeated. Bubbles inside the pipeline are not squeezed out during a stall;
// they move on with the words around them.
// Reset empties the pipeline and loads radius 1.0, 36 sectors and 18 stacks.
module uv_sphere_vertex_generator (
   input  logic        clock,
   input  logic        reset,
   uvsv_req_if.sink    req_ch,
   uvsv_rsp_if.source  rsp_ch,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int CB  = uvsv_pkg::COUNT_BITS;
   localparam int AB  = uvsv_pkg::ANGLE_BITS;
   localparam int DW  = uvsv_pkg::DIV_W;
   localparam int QW  = uvsv_pkg::QUO_W;
   localparam int MW  = uvsv_pkg::MAG_W;
   localparam int LAT = uvsv_pkg::LATENCY;
   localparam logic [AB-1:0] QUARTER = AB'(1) << (AB - 2);

   logic [15:0]   radius_ff;
   logic [CB-1:0] sector_ff, stack_ff;
   logic [LAT-1:0] valid_ff;
   logic           en;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= uvsv_pkg::RADIUS_ONE;
         sector_ff <= CB'(36);
         stack_ff  <= CB'(18);
      end else if (csr_write_en) begin
         unique case (csr_index)
            uvsv_pkg::REG_RADIUS: radius_ff <= csr_wdata;
            uvsv_pkg::REG_SECTOR: sector_ff <= csr_wdata[CB-1:0];
            uvsv_pkg::REG_STACK:  stack_ff  <= csr_wdata[CB-1:0];
            default: ;
         endcase
      end
   end

   // The pipeline moves whenever the output register is free or being taken.
   assign en           = !valid_ff[LAT-1] || rsp_ch.ready;
   assign req_ch.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[LAT-2:0], req_ch.valid};
      end
   end

   // Clamp counts and indices and form the two dividends.
   logic [CB-1:0] s_eff, t_eff, i_eff, j_eff;
   logic [DW-1:0] dv_in, du_in, dv_ff, du_ff;
   logic [CB-1:0] s_ff, t_ff;

   assign s_eff = (sector_ff < CB'(uvsv_pkg::SECTOR_COUNT_FLOOR)) ?
                  CB'(uvsv_pkg::SECTOR_COUNT_FLOOR) : sector_ff;
   assign t_eff = (stack_ff < CB'(uvsv_pkg::STACK_COUNT_FLOOR)) ?
                  CB'(uvsv_pkg::STACK_COUNT_FLOOR) : stack_ff;
   assign j_eff = (req_ch.sector_index > s_eff) ? s_eff : req_ch.sector_index;
   assign i_eff = (req_ch.stack_index > t_eff) ? t_eff : req_ch.stack_index;
   assign dv_in = (DW'(j_eff) << AB) + DW'(s_eff >> 1);
   assign du_in = (DW'(i_eff) << (AB - 1)) + DW'(t_eff >> 1);

   always_ff @(posedge clock) begin
      if (en) begin
         dv_ff <= dv_in;
         du_ff <= du_in;
         s_ff  <= s_eff;
         t_ff  <= t_eff;
      end
   end

   // Angle phases from the two dividers.
   logic [QW-1:0] qv, qu;
   logic [AB-1:0] vph, uph;

   uvsv_divider u_div_v (
      .clock(clock), .en(en), .dividend(dv_ff), .divisor(s_ff), .quotient(qv)
   );
   uvsv_divider u_div_u (
      .clock(clock), .en(en), .dividend(du_ff), .divisor(t_ff), .quotient(qu)
   );

   assign vph = qv[AB-1:0];
   assign uph = QUARTER - qu[AB-1:0];

   // Four sines; a cosine is the sine a quarter turn on.
   logic [MW-1:0] su, cu, sv, cv;
   logic          nsu, ncu, nsv, ncv;

   uvsv_sine u_sin_u (.clock(clock), .en(en), .phase(uph),           .mag(su), .neg(nsu));
   uvsv_sine u_cos_u (.clock(clock), .en(en), .phase(uph + QUARTER), .mag(cu), .neg(ncu));
   uvsv_sine u_sin_v (.clock(clock), .en(en), .phase(vph),           .mag(sv), .neg(nsv));
   uvsv_sine u_cos_v (.clock(clock), .en(en), .phase(vph + QUARTER), .mag(cv), .neg(ncv));

   // Latitude-longitude products rounded to Q30.
   logic [61:0]   cc_prod, cs_prod;
   logic [MW-1:0] cc_ff, cs_ff, su_ff;
   logic          ncc_ff, ncs_ff, nsu_ff;

   assign cc_prod = cu * cv + 62'(1) * (62'(1) << 29);
   assign cs_prod = cu * sv + (62'(1) << 29);

   always_ff @(posedge clock) begin
      if (en) begin
         cc_ff  <= cc_prod[60:30];
         cs_ff  <= cs_prod[60:30];
         su_ff  <= su;
         ncc_ff <= ncu ^ ncv;
         ncs_ff <= ncu ^ nsv;
         nsu_ff <= nsu;
      end
   end

   // Scale by the radius, round and apply the signs.
   logic [15:0] r_eff;
   logic [46:0] px_prod, py_prod, pz_prod;
   logic [16:0] px_mag, py_mag, pz_mag;
   logic [15:0] nx_mag, ny_mag, nz_mag;
   logic [MW:0] nx_sum, ny_sum, nz_sum;
   logic signed [16:0] pos_x_ff, pos_y_ff, pos_z_ff;
   logic signed [15:0] norm_x_ff, norm_y_ff, norm_z_ff;

   assign r_eff   = (radius_ff == '0) ? uvsv_pkg::RADIUS_ONE : radius_ff;
   assign px_prod = 47'(r_eff) * 47'(cc_ff) + (47'(1) << 29);
   assign py_prod = 47'(r_eff) * 47'(cs_ff) + (47'(1) << 29);
   assign pz_prod = 47'(r_eff) * 47'(su_ff) + (47'(1) << 29);
   assign px_mag  = px_prod[46:30];
   assign py_mag  = py_prod[46:30];
   assign pz_mag  = pz_prod[46:30];
   assign nx_sum  = {1'b0, cc_ff} + (32'(1) << 15);
   assign ny_sum  = {1'b0, cs_ff} + (32'(1) << 15);
   assign nz_sum  = {1'b0, su_ff} + (32'(1) << 15);
   assign nx_mag  = nx_sum[31:16];
   assign ny_mag  = ny_sum[31:16];
   assign nz_mag  = nz_sum[31:16];

   always_ff @(posedge clock) begin
      if (en) begin
         pos_x_ff  <= ncc_ff ? -$signed(px_mag) : $signed(px_mag);
         pos_y_ff  <= ncs_ff ? -$signed(py_mag) : $signed(py_mag);
         pos_z_ff  <= nsu_ff ? -$signed(pz_mag) : $signed(pz_mag);
         norm_x_ff <= ncc_ff ? -$signed(nx_mag) : $signed(nx_mag);
         norm_y_ff <= ncs_ff ? -$signed(ny_mag) : $signed(ny_mag);
         norm_z_ff <= nsu_ff ? -$signed(nz_mag) : $signed(nz_mag);
      end
   end

   assign rsp_ch.valid  = valid_ff[LAT-1];
   assign rsp_ch.pos_x  = pos_x_ff;
   assign rsp_ch.pos_y  = pos_y_ff;
   assign rsp_ch.pos_z  = pos_z_ff;
   assign rsp_ch.norm_x = norm_x_ff;
   assign rsp_ch.norm_y = norm_y_ff;
   assign rsp_ch.norm_z = norm_z_ff;

endmodule
